FILE: hw/rtl/lru_pr_pkg.sv
// ---------------------------------------------------------------------------
// lru_pr_pkg
// Shared types and constants of the lru page replacement core.
// ---------------------------------------------------------------------------
`default_nettype none

package lru_pr_pkg;

  localparam int unsigned CFG_W         = 5;
  localparam int unsigned FRAME_INDEX_W = 4;
  localparam int unsigned FAULT_W       = 32;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic update;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lru_pr_ctrl.sv
// ---------------------------------------------------------------------------
// lru_pr_ctrl
// Sequencer: accept a reference, run the frame scan, then commit the update.
// ---------------------------------------------------------------------------
`default_nettype none

module lru_pr_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire lru_pr_pkg::ctrl_sts_t sts,
  output lru_pr_pkg::ctrl_cmd_t      cmd
);

  lru_pr_pkg::state_t state;
  lru_pr_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lru_pr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      lru_pr_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = lru_pr_pkg::ST_SCAN;
        end
      end
      lru_pr_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = lru_pr_pkg::ST_UPDATE;
        end
      end
      lru_pr_pkg::ST_UPDATE: begin
        // commit only once the result register can take the answer
        if (sts.out_free) begin
          cmd.update = 1'b1;
          state_next = lru_pr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lru_pr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lru_pr_datapath.sv
// ---------------------------------------------------------------------------
// lru_pr_datapath
// Frame store, recency ranks, fault counter, scan unit and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module lru_pr_datapath #(
  parameter int unsigned MAX_FRAMES = 16,
  parameter int unsigned PAGE_BITS  = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [lru_pr_pkg::CFG_W-1:0]         cfg_wr_data,
  input  wire logic [PAGE_BITS-1:0]                 page_number,
  input  wire logic                                 end_of_sequence,
  input  wire lru_pr_pkg::ctrl_cmd_t                cmd,
  output lru_pr_pkg::ctrl_sts_t                     sts,
  input  wire logic                                 out_stall,
  output logic                                      out_valid,
  output logic                                      hit,
  output logic [lru_pr_pkg::FRAME_INDEX_W-1:0]      frame_index,
  output logic [PAGE_BITS-1:0]                      evicted_page,
  output logic                                      evicted_valid,
  output logic [lru_pr_pkg::FAULT_W-1:0]            fault_count
);

  localparam int unsigned FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned RW = FW;
  localparam int unsigned CW = $clog2(MAX_FRAMES + 1);
  localparam logic [RW-1:0] RANK_TOP = RW'(MAX_FRAMES - 1);

  logic [lru_pr_pkg::CFG_W-1:0] frames_in_use;
  logic [CW-1:0]                nact;

  logic [PAGE_BITS-1:0] frame_page [MAX_FRAMES];
  logic [PAGE_BITS-1:0] mem_rdata;
  logic [MAX_FRAMES-1:0] frame_valid;
  logic [RW-1:0]        recency_rank [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] frame_valid_next;
  logic [RW-1:0]        recency_rank_next [MAX_FRAMES];
  logic [lru_pr_pkg::FAULT_W-1:0] fault_total;
  logic [lru_pr_pkg::FAULT_W-1:0] fault_total_next;

  logic [PAGE_BITS-1:0] page_q;
  logic                 eos_q;

  // scan state
  logic [CW-1:0] addr;
  logic          stage_vld;
  logic [FW-1:0] stage_idx;
  logic          found;
  logic [FW-1:0] match_idx;
  logic [RW-1:0] match_rank;
  logic          empty_found;
  logic [FW-1:0] empty_idx;
  logic [RW-1:0] best_rank;
  logic [FW-1:0] vict_idx;
  logic [PAGE_BITS-1:0] vict_page;

  logic [FW-1:0] sel_idx;
  logic          use_all;
  logic [RW-1:0] limit;
  logic          miss;
  logic          evict;

  always_comb begin
    if (frames_in_use == '0) begin
      nact = CW'(1);
    end else if (32'(frames_in_use) > MAX_FRAMES) begin
      nact = CW'(MAX_FRAMES);
    end else begin
      nact = CW'(frames_in_use);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= lru_pr_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      frames_in_use <= cfg_wr_data;
    end
  end

  assign sts.scan_done = (addr == nact) && !stage_vld;
  assign sts.out_free  = !out_valid || !out_stall;

  // frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.update && miss) begin
      frame_page[sel_idx] <= page_q;
    end
    mem_rdata <= frame_page[addr[FW-1:0]];
  end

  // scan address and compare stage
  always_ff @(posedge clk) begin
    if (rst) begin
      addr      <= '0;
      stage_vld <= 1'b0;
    end else if (cmd.load) begin
      addr      <= '0;
      stage_vld <= 1'b0;
    end else if (cmd.scan && addr != nact) begin
      addr      <= addr + CW'(1);
      stage_vld <= 1'b1;
    end else begin
      stage_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_q      <= page_number;
      eos_q       <= end_of_sequence;
      found       <= 1'b0;
      empty_found <= 1'b0;
      stage_idx   <= '0;
    end else begin
      if (cmd.scan && addr != nact) begin
        stage_idx <= addr[FW-1:0];
      end
      if (stage_vld) begin
        if (!found && frame_valid[stage_idx] && mem_rdata == page_q) begin
          found      <= 1'b1;
          match_idx  <= stage_idx;
          match_rank <= recency_rank[stage_idx];
        end
        if (!empty_found && !frame_valid[stage_idx]) begin
          empty_found <= 1'b1;
          empty_idx   <= stage_idx;
        end
        // frame zero seeds the victim, later frames must be strictly older
        if (stage_idx == '0 || recency_rank[stage_idx] > best_rank) begin
          best_rank <= recency_rank[stage_idx];
          vict_idx  <= stage_idx;
          vict_page <= mem_rdata;
        end
      end
    end
  end

  assign miss  = !found;
  assign evict = !found && !empty_found;

  always_comb begin
    if (found) begin
      sel_idx = match_idx;
    end else if (empty_found) begin
      sel_idx = empty_idx;
    end else begin
      sel_idx = vict_idx;
    end
    use_all = !found && empty_found;
    limit   = found ? match_rank : best_rank;
  end

  always_comb begin
    frame_valid_next = frame_valid;
    fault_total_next = fault_total;
    for (int j = 0; j < MAX_FRAMES; j++) begin
      recency_rank_next[j] = recency_rank[j];
      if (CW'(j) < nact && FW'(j) != sel_idx && frame_valid[j] &&
          (use_all || recency_rank[j] < limit) && recency_rank[j] < RANK_TOP) begin
        recency_rank_next[j] = recency_rank[j] + RW'(1);
      end
    end
    recency_rank_next[sel_idx] = '0;
    if (miss) begin
      frame_valid_next[sel_idx] = 1'b1;
      if (fault_total != '1) begin
        fault_total_next = fault_total + lru_pr_pkg::FAULT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= '0;
      fault_total <= '0;
      for (int j = 0; j < MAX_FRAMES; j++) begin
        recency_rank[j] <= '0;
      end
    end else if (cmd.update) begin
      if (eos_q) begin
        frame_valid <= '0;
        fault_total <= '0;
        for (int j = 0; j < MAX_FRAMES; j++) begin
          recency_rank[j] <= '0;
        end
      end else begin
        frame_valid <= frame_valid_next;
        fault_total <= fault_total_next;
        for (int j = 0; j < MAX_FRAMES; j++) begin
          recency_rank[j] <= recency_rank_next[j];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.update) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      hit           <= found;
      frame_index   <= lru_pr_pkg::FRAME_INDEX_W'(sel_idx);
      evicted_page  <= evict ? vict_page : '0;
      evicted_valid <= evict;
      fault_count   <= fault_total_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lru_page_replacement_core.sv
// ---------------------------------------------------------------------------
// lru_page_replacement_core
// LRU page replacement unit with saturating fault counter.
// ---------------------------------------------------------------------------
`default_nettype none

// Each transfer on the input carries one page reference and returns one result:
// hit flag, frame holding the page, evicted page and the fault count. Only the
// first frames_in_use frames take part (0 acts as 1, values above MAX_FRAMES act
// as MAX_FRAMES). A reference is handled in steps: a scan of the active frames
// one per cycle through the registered read port of the frame store, the
// compare of the registered read data, a step in which the scan reports done,
// and a commit that updates ranks, frame and counter and loads the result. The
// next reference is taken on the cycle after the commit, so a new reference is
// not accepted while one is in flight. The previous result may still wait in
// the output register while the next reference is scanned; the commit then
// waits until that result has been transferred. frames_in_use must be written
// only while idle; the block itself does not enforce it.
module lru_page_replacement_core #(
  parameter int unsigned MAX_FRAMES = 16,
  parameter int unsigned PAGE_BITS  = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wr_en,
  input  wire logic [lru_pr_pkg::CFG_W-1:0]     cfg_wr_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [PAGE_BITS-1:0]             page_number,
  input  wire logic                             end_of_sequence,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  hit,
  output logic [lru_pr_pkg::FRAME_INDEX_W-1:0]  frame_index,
  output logic [PAGE_BITS-1:0]                  evicted_page,
  output logic                                  evicted_valid,
  output logic [lru_pr_pkg::FAULT_W-1:0]        fault_count
);

  lru_pr_pkg::ctrl_cmd_t cmd;
  lru_pr_pkg::ctrl_sts_t sts;

  lru_pr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lru_pr_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .page_number     (page_number),
    .end_of_sequence (end_of_sequence),
    .cmd             (cmd),
    .sts             (sts),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .hit             (hit),
    .frame_index     (frame_index),
    .evicted_page    (evicted_page),
    .evicted_valid   (evicted_valid),
    .fault_count     (fault_count)
  );

  // one reference in flight: after a transfer the input stays stalled
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a reference is in flight");

  // a miss always counts, and the counter never wraps to zero
  a_fault_counted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (fault_count != '0))
    else $error("page fault with zero fault count");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> (!evicted_valid && evicted_page == '0))
    else $error("hit reports an eviction");

  a_commit_clean: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> (!cmd.load && !cmd.scan && sts.scan_done))
    else $error("commit issued during scan");

endmodule

`default_nettype wire
